/* design/smpq_pkg.sv */
package smpq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned OCC_W     = 5;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_tag;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_SCAN_END,
    CS_SHIFT_SET,
    CS_SHIFT,
    CS_RESP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic resp_imm;
    logic scan_start;
    logic scan_rd;
    logic shift_set;
    logic shift_rd;
    logic resp_deq;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic idx_at_count;
    logic out_free;
  } sts_t;

endpackage

/* design/smpq_ctrl.sv */
module smpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_ready_o,
  input  smpq_pkg::sts_t sts_i,
  output smpq_pkg::cmd_t cmd_o
);

  smpq_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smpq_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      smpq_pkg::CS_IDLE: begin
        if (accept && req_type_i == smpq_pkg::REQ_DEQUEUE && !sts_i.count_zero) begin
          state_d = smpq_pkg::CS_SCAN;
        end
      end
      smpq_pkg::CS_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = smpq_pkg::CS_SCAN_END;
        end
      end
      smpq_pkg::CS_SCAN_END:  state_d = smpq_pkg::CS_SHIFT_SET;
      smpq_pkg::CS_SHIFT_SET: state_d = smpq_pkg::CS_SHIFT;
      smpq_pkg::CS_SHIFT: begin
        if (sts_i.idx_at_count) begin
          state_d = smpq_pkg::CS_RESP;
        end
      end
      smpq_pkg::CS_RESP: begin
        if (sts_i.out_free) begin
          state_d = smpq_pkg::CS_IDLE;
        end
      end
      default: state_d = smpq_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      smpq_pkg::CS_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (accept) begin
          // Inserts and empty dequeues finish in the cycle of the transaction.
          if (req_type_i == smpq_pkg::REQ_INSERT || sts_i.count_zero) begin
            cmd_o.resp_imm = 1'b1;
          end else begin
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      smpq_pkg::CS_SCAN:      cmd_o.scan_rd = 1'b1;
      smpq_pkg::CS_SCAN_END:  cmd_o = '0;
      smpq_pkg::CS_SHIFT_SET: cmd_o.shift_set = 1'b1;
      smpq_pkg::CS_SHIFT:     cmd_o.shift_rd = !sts_i.idx_at_count;
      smpq_pkg::CS_RESP:      cmd_o.resp_deq = sts_i.out_free;
      default:                cmd_o = '0;
    endcase
  end

endmodule

/* design/smpq_datapath.sv */
module smpq_datapath #(
  parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  smpq_pkg::req_t in_req_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output smpq_pkg::rsp_t out_rsp_o,
  input  smpq_pkg::cmd_t cmd_i,
  output smpq_pkg::sts_t sts_o
);

  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned WORDW = smpq_pkg::PRIO_W + smpq_pkg::TAG_W;

  logic [WORDW-1:0] mem_q [DEPTH];
  logic [WORDW-1:0] rd_q;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             scan_vld_q, scan_first_q;
  logic             shift_vld_q;
  logic [IW-1:0]    shift_idx_q;
  logic [IW-1:0]    best_idx_q;
  logic [WORDW-1:0] best_q;
  logic             out_valid_q;
  smpq_pkg::rsp_t   rsp_q, rsp_d;

  logic             rd_en, wr_en, ins_en, full, load;
  logic [IW-1:0]    wr_addr;
  logic [WORDW-1:0] wr_data;
  logic [CW-1:0]    occ_src;
  logic [CW+smpq_pkg::OCC_W-1:0] occ_ext;

  assign full   = (count_q == CW'(DEPTH));
  assign ins_en = cmd_i.resp_imm && (in_req_i.req_type == smpq_pkg::REQ_INSERT) && !full;
  assign rd_en  = cmd_i.scan_rd || cmd_i.shift_rd;
  assign wr_en  = ins_en || shift_vld_q;
  // A shift moves the word read from one slot up into the slot below it.
  assign wr_addr = ins_en ? count_q[IW-1:0] : shift_idx_q - IW'(1);
  assign wr_data = ins_en ? {in_req_i.priority_req, in_req_i.tag} : rd_q;
  assign load    = cmd_i.resp_imm || cmd_i.resp_deq;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[IW-1:0]];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_start) begin
      idx_d = '0;
    end else if (cmd_i.scan_rd || cmd_i.shift_rd) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.shift_set) begin
      idx_d = CW'(best_idx_q) + CW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.resp_deq) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      scan_vld_q  <= 1'b0;
      shift_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      scan_vld_q  <= cmd_i.scan_rd;
      shift_vld_q <= cmd_i.shift_rd;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Strict less-than keeps the earliest entry on equal priorities.
  always_ff @(posedge clk_i) begin
    scan_first_q <= (idx_q == '0);
    shift_idx_q  <= idx_q[IW-1:0];
    if (scan_vld_q) begin
      if (scan_first_q ||
          rd_q[WORDW-1 -: smpq_pkg::PRIO_W] < best_q[WORDW-1 -: smpq_pkg::PRIO_W]) begin
        best_q     <= rd_q;
        best_idx_q <= shift_idx_q;
      end
    end
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    rsp_d   = '0;
    occ_src = count_q;
    if (cmd_i.resp_deq) begin
      rsp_d.status       = smpq_pkg::ST_DEQUEUED;
      rsp_d.out_priority = best_q[WORDW-1 -: smpq_pkg::PRIO_W];
      rsp_d.out_tag      = best_q[smpq_pkg::TAG_W-1:0];
      occ_src            = count_q - CW'(1);
    end else if (in_req_i.req_type == smpq_pkg::REQ_INSERT) begin
      if (full) begin
        rsp_d.status = smpq_pkg::ST_FULL;
      end else begin
        rsp_d.status = smpq_pkg::ST_INSERTED;
        occ_src      = count_q + CW'(1);
      end
    end else begin
      rsp_d.status = smpq_pkg::ST_EMPTY;
    end
    occ_ext         = (CW + smpq_pkg::OCC_W)'(occ_src);
    rsp_d.occupancy = occ_ext[smpq_pkg::OCC_W-1:0];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign sts_o.count_zero   = (count_q == '0);
  assign sts_o.scan_last    = (idx_q == count_q - CW'(1));
  assign sts_o.idx_at_count = (idx_q == count_q);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_en && shift_vld_q))
    else $error("insert write collides with shift write");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> idx_q < count_q)
    else $error("read beyond the valid entries");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an untaken result");

endmodule

/* design/stable_min_priority_queue.sv */
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+-----------------------
// in      | input     | in_valid_i / in_ready_o   | in_req_i  (req_t)
// out     | output    | out_valid_o / out_ready_i | out_rsp_o (rsp_t)
//
// An insert, and a dequeue on an empty queue, completes in the cycle of its
// transaction and its result is held in the output register from the next cycle.
// A dequeue on a non-empty queue scans the single-read-port entry memory for the
// minimum, then shifts the later entries down, one read and one write per cycle.
// Reset clears the entry count, the controller state and the output valid flag;
// the entry memory needs no clearing pass.
// A stalled result holds the output register, and no new transaction is taken
// until it can be replaced.
module stable_min_priority_queue #(
  parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smpq_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smpq_pkg::rsp_t out_rsp_o
);

  smpq_pkg::cmd_t cmd;
  smpq_pkg::sts_t sts;

  smpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_req_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
